[hw/rtl/lho_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Latency histogram package
// Shared widths, command and status codes, register indexes and the request
// record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package lho_pkg;

	// Default sizes, handed to the top level parameters.
	localparam int BUCKETS_DEF       = 1024;
	localparam int OUTLIER_SLOTS_DEF = 64;

	// Field widths.
	localparam int CMD_W     = 2;
	localparam int LAT_W     = 32;
	localparam int INDEX_W   = 10;
	localparam int STATUS_W  = 2;
	localparam int CNT_W     = 64;
	localparam int S_DATA_W  = 48;   // latency + index, padded to whole bytes
	localparam int M_DATA_W  = 320;  // value + four running totals

	// Configuration port.
	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 32;
	localparam int SHIFT_W    = 5;
	localparam int LIMIT_W    = 7;

	localparam logic [CFG_ADDR_W-1:0] REG_BIN_CEILING   = 8'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BUCKET_SHIFT  = 8'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_OUTLIER_LIMIT = 8'd2;

	localparam logic [LAT_W-1:0]   BIN_CEILING_RST   = 32'd1024;
	localparam logic [SHIFT_W-1:0] BUCKET_SHIFT_RST  = 5'd0;
	localparam logic [LIMIT_W-1:0] OUTLIER_LIMIT_RST = 7'd64;

	// Commands.
	localparam logic [CMD_W-1:0] CMD_ADD        = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RD_BUCKET  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RD_OUTLIER = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_IDX_ERR = 2'd2;

	// Classified request, as it sits in the front end queue.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [LAT_W-1:0] latency;
		logic [LAT_W-1:0] slot;      // bucket number for adds, index for reads
		logic             in_range;  // slot lies inside the bucket range
	} op_t;

endpackage
`default_nettype wire

[hw/rtl/lho_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read; the read data
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module lho_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/lho_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Latency histogram front end
// Accepts requests, works out the bucket number and range check, and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lho_front #(
	parameter int BUCKETS = lho_pkg::BUCKETS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [lho_pkg::CMD_W-1:0]       s_tuser,  // cmd
	input  wire logic [lho_pkg::S_DATA_W-1:0]    s_tdata,  // latency, index, pad
	input  wire logic [lho_pkg::LAT_W-1:0]       bin_ceiling,
	input  wire logic [lho_pkg::SHIFT_W-1:0]     bucket_shift,
	input  wire logic                            clearing,
	output logic                                 q_valid,
	output lho_pkg::op_t                         q_op,
	input  wire logic                            q_pop
);
	import lho_pkg::*;

	logic [LAT_W-1:0]   latency;
	logic [INDEX_W-1:0] index;
	logic [LAT_W-1:0]   bkt;
	logic [LAT_W-1:0]   span;
	logic [LAT_W-1:0]   range;
	op_t                in_op;
	logic               push;

	op_t        ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign latency = s_tdata[LAT_W-1:0];
	assign index   = s_tdata[LAT_W+INDEX_W-1:LAT_W];

	// Bucket number and the number of buckets in use at this shift.
	always_comb begin
		bkt   = latency >> bucket_shift;
		span  = bin_ceiling >> bucket_shift;
		range = (span < LAT_W'(BUCKETS)) ? span : LAT_W'(BUCKETS);
		in_op.cmd      = s_tuser;
		in_op.latency  = latency;
		in_op.slot     = (s_tuser == CMD_ADD) ? bkt : LAT_W'(index);
		in_op.in_range = in_op.slot < range;
	end

	assign s_tready = (cnt_q != 2'd2) && !clearing;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_op     = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/lho_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Latency histogram back end
// Clears the bucket memory after reset, then carries out queued requests:
// bucket read-modify-write, outlier capture, reads and running totals.
// ----------------------------------------------------------------------------
module lho_back #(
	parameter int BUCKETS       = lho_pkg::BUCKETS_DEF,
	parameter int OUTLIER_SLOTS = lho_pkg::OUTLIER_SLOTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [lho_pkg::LIMIT_W-1:0]     outlier_limit,
	output logic                                 clearing,
	input  wire logic                            q_valid,
	input  wire lho_pkg::op_t                    q_op,
	output logic                                 q_pop,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [lho_pkg::STATUS_W-1:0]         m_tuser,  // status
	// value, total_count, latency_sum, square_sum, outlier_count
	output logic [lho_pkg::M_DATA_W-1:0]         m_tdata
);
	import lho_pkg::*;

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int OW = (OUTLIER_SLOTS > 1) ? $clog2(OUTLIER_SLOTS) : 1;
	localparam int FW = $clog2(OUTLIER_SLOTS + 1);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_ISSUE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic [BW-1:0]      clr_addr_q;
	op_t                op_q;
	logic [CNT_W-1:0]   sq_q;
	logic [FW-1:0]      fill_q;
	logic [CNT_W-1:0]   sample_total_q;
	logic [CNT_W-1:0]   running_sum_q;
	logic [CNT_W-1:0]   square_sum_q;
	logic [CNT_W-1:0]   outlier_total_q;
	logic               m_valid_q;
	logic [STATUS_W-1:0] m_status_q;
	logic [CNT_W-1:0]   m_value_q;

	logic               bkt_we;
	logic [BW-1:0]      bkt_waddr;
	logic [CNT_W-1:0]   bkt_wdata;
	logic [BW-1:0]      bkt_raddr;
	logic [CNT_W-1:0]   bkt_rdata;
	logic               ol_we;
	logic [OW-1:0]      ol_waddr;
	logic [OW-1:0]      ol_raddr;
	logic [LAT_W-1:0]   ol_rdata;
	logic               out_free;
	logic               commit;
	logic               is_add;
	logic               is_outlier;
	logic [LAT_W-1:0]   store_lim;
	logic               store_full;
	logic [STATUS_W-1:0] res_status;
	logic [CNT_W-1:0]   res_value;

	lho_ram #(.WIDTH(CNT_W), .DEPTH(BUCKETS)) u_bucket_ram (
		.clk   (clk),
		.we    (bkt_we),
		.waddr (bkt_waddr),
		.wdata (bkt_wdata),
		.re    (q_pop),
		.raddr (bkt_raddr),
		.rdata (bkt_rdata)
	);

	lho_ram #(.WIDTH(LAT_W), .DEPTH(OUTLIER_SLOTS)) u_outlier_ram (
		.clk   (clk),
		.we    (ol_we),
		.waddr (ol_waddr),
		.wdata (op_q.latency),
		.re    (q_pop),
		.raddr (ol_raddr),
		.rdata (ol_rdata)
	);

	assign clearing  = state_q == S_CLEAR;
	assign q_pop     = (state_q == S_ISSUE) && q_valid;
	assign bkt_raddr = BW'(q_op.slot);
	assign ol_raddr  = OW'(q_op.slot);
	assign out_free  = !m_valid_q || m_tready;
	assign commit    = (state_q == S_EXEC) && out_free;
	assign is_add    = op_q.cmd == CMD_ADD;
	assign is_outlier = is_add && !op_q.in_range;

	assign store_lim  = (LAT_W'(outlier_limit) < LAT_W'(OUTLIER_SLOTS)) ?
	                    LAT_W'(outlier_limit) : LAT_W'(OUTLIER_SLOTS);
	assign store_full = LAT_W'(fill_q) >= store_lim;

	always_comb begin
		bkt_we     = 1'b0;
		bkt_waddr  = BW'(op_q.slot);
		bkt_wdata  = bkt_rdata + CNT_W'(1);
		ol_we      = 1'b0;
		ol_waddr   = OW'(fill_q);
		res_status = ST_OK;
		res_value  = '0;
		if (state_q == S_CLEAR) begin
			bkt_we    = 1'b1;
			bkt_waddr = clr_addr_q;
			bkt_wdata = '0;
		end else if (commit) begin
			case (op_q.cmd)
				CMD_ADD: begin
					if (op_q.in_range) begin
						bkt_we = 1'b1;
					end else if (store_full) begin
						res_status = ST_FULL;
					end else begin
						ol_we = 1'b1;
					end
				end
				CMD_RD_BUCKET: begin
					if (op_q.in_range) begin
						res_value = bkt_rdata;
					end else begin
						res_status = ST_IDX_ERR;
					end
				end
				CMD_RD_OUTLIER: begin
					if (op_q.slot < LAT_W'(fill_q)) begin
						res_value = CNT_W'(ol_rdata);
					end else begin
						res_status = ST_IDX_ERR;
					end
				end
				default: begin
					res_status = ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_op;
			sq_q <= CNT_W'(q_op.latency) * CNT_W'(q_op.latency);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_addr_q      <= '0;
			fill_q          <= '0;
			sample_total_q  <= '0;
			running_sum_q   <= '0;
			square_sum_q    <= '0;
			outlier_total_q <= '0;
			m_valid_q       <= 1'b0;
			m_status_q      <= ST_OK;
			m_value_q       <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + BW'(1);
					if (clr_addr_q == BW'(BUCKETS - 1)) begin
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (q_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_ISSUE;
					end
				end
				default: begin
					state_q <= S_ISSUE;
				end
			endcase

			if (commit && is_add) begin
				sample_total_q <= sample_total_q + CNT_W'(1);
				running_sum_q  <= running_sum_q + CNT_W'(op_q.latency);
				square_sum_q   <= square_sum_q + sq_q;
			end
			if (commit && is_outlier) begin
				outlier_total_q <= outlier_total_q + CNT_W'(1);
			end
			if (ol_we) begin
				fill_q <= fill_q + FW'(1);
			end

			if (commit) begin
				m_status_q <= res_status;
				m_value_q  <= res_value;
			end

			if (commit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// The totals only move when a new result is loaded, so they can feed the
	// output directly.
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {outlier_total_q, square_sum_q, running_sum_q,
	                   sample_total_q, m_value_q};

endmodule
`default_nettype wire

[hw/rtl/latency_histogram_with_outliers_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Latency histogram with outlier capture
// Bins latency samples into power-of-two wide buckets, captures samples
// beyond the bucket range, and keeps running count, sum and sum of squares.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         tvalid/tready      tuser: cmd; tdata: latency, index
//  m_*       out        tvalid/tready      tuser: status; tdata: value and totals
//  cfg_*     in         cfg_we only        bin_ceiling, bucket_shift, outlier_limit
//
// In the back end each request is read from memory in S_ISSUE, then its
// bucket update and result load happen in S_EXEC, which waits while the
// result register is full; the next request is taken only after that. After
// reset the bucket memory is cleared one entry per cycle, with s_tready low;
// register writes are still taken. A two-entry queue and the result register
// keep input flowing while a finished result waits on m_tready.
//
module latency_histogram_with_outliers_core #(
	parameter int BUCKETS       = lho_pkg::BUCKETS_DEF,
	parameter int OUTLIER_SLOTS = lho_pkg::OUTLIER_SLOTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Request stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [lho_pkg::CMD_W-1:0]       s_tuser,  // [1:0] cmd
	// [31:0] latency, [41:32] index, [47:42] zero pad
	input  wire logic [lho_pkg::S_DATA_W-1:0]    s_tdata,
	// Result stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [lho_pkg::STATUS_W-1:0]         m_tuser,  // [1:0] status
	// [63:0] value, [127:64] total_count, [191:128] latency_sum,
	// [255:192] square_sum, [319:256] outlier_count
	output logic [lho_pkg::M_DATA_W-1:0]         m_tdata,
	// Register writes
	input  wire logic                            cfg_we,
	input  wire logic [lho_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [lho_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import lho_pkg::*;

	logic [LAT_W-1:0]   bin_ceiling_q;
	logic [SHIFT_W-1:0] bucket_shift_q;
	logic [LIMIT_W-1:0] outlier_limit_q;

	logic clearing;
	logic q_valid;
	op_t  q_op;
	logic q_pop;

	// Configuration registers. Writes to unknown indexes are dropped; nothing
	// else is cleared by a write, so stored outliers stay readable even when
	// the limit is lowered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_ceiling_q   <= BIN_CEILING_RST;
			bucket_shift_q  <= BUCKET_SHIFT_RST;
			outlier_limit_q <= OUTLIER_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BIN_CEILING: begin
					bin_ceiling_q <= cfg_wdata[LAT_W-1:0];
				end
				REG_BUCKET_SHIFT: begin
					bucket_shift_q <= cfg_wdata[SHIFT_W-1:0];
				end
				REG_OUTLIER_LIMIT: begin
					outlier_limit_q <= cfg_wdata[LIMIT_W-1:0];
				end
				default: begin
					bin_ceiling_q <= bin_ceiling_q;
				end
			endcase
		end
	end

	// Front end: accepts requests, computes the bucket number and whether it
	// falls inside the active range, and queues the classified request.
	lho_front #(.BUCKETS(BUCKETS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tuser      (s_tuser),
		.s_tdata      (s_tdata),
		.bin_ceiling  (bin_ceiling_q),
		.bucket_shift (bucket_shift_q),
		.clearing     (clearing),
		.q_valid      (q_valid),
		.q_op         (q_op),
		.q_pop        (q_pop)
	);

	// Back end: owns both memories and all running totals, and drives the
	// result register.
	lho_back #(.BUCKETS(BUCKETS), .OUTLIER_SLOTS(OUTLIER_SLOTS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.outlier_limit (outlier_limit_q),
		.clearing      (clearing),
		.q_valid       (q_valid),
		.q_op          (q_op),
		.q_pop         (q_pop),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tuser       (m_tuser),
		.m_tdata       (m_tdata)
	);

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram testbench
// Sends add, read and unknown requests through the request stream under
// several register settings and idle patterns. A local model of the histogram
// predicts every result, and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb;
	import lho_pkg::*;

	localparam int NUM_BUCKETS     = BUCKETS_DEF;
	localparam int NUM_SLOTS       = OUTLIER_SLOTS_DEF;
	localparam int BKT_W           = $clog2(NUM_BUCKETS);
	localparam int SLOT_W          = $clog2(NUM_SLOTS);
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 20;
	localparam int MAX_REPORTS     = 200;

	localparam logic [CMD_W-1:0]      CMD_UNKNOWN  = 2'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 8'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    value;
		logic [CNT_W-1:0]    samples;
		logic [CNT_W-1:0]    lat_sum;
		logic [CNT_W-1:0]    sq_sum;
		logic [CNT_W-1:0]    outliers;
	} hist_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [CMD_W-1:0]      s_tuser   = '0;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [STATUS_W-1:0]   m_tuser;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Local copy of the histogram state and its registers.
	logic [LAT_W-1:0]   cfg_bin_ceiling = BIN_CEILING_RST;
	logic [SHIFT_W-1:0] cfg_shift       = BUCKET_SHIFT_RST;
	logic [LIMIT_W-1:0] cfg_limit       = OUTLIER_LIMIT_RST;
	logic [CNT_W-1:0]   bucket_count [NUM_BUCKETS] = '{default: '0};
	logic [LAT_W-1:0]   captured [NUM_SLOTS];
	int                 captured_fill = 0;
	logic [CNT_W-1:0]   sample_cnt    = '0;
	logic [CNT_W-1:0]   lat_total     = '0;
	logic [CNT_W-1:0]   sq_total      = '0;
	logic [CNT_W-1:0]   outlier_cnt   = '0;

	hist_result_t expected_results [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_req       = 1'b0;
	int error_cnt      = 0;
	int quiet_cycles   = 0;

	latency_histogram_with_outliers_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Number of buckets in use under the current settings.
	function automatic int bucket_span();
		logic [LAT_W-1:0] span;
		span = cfg_bin_ceiling >> cfg_shift;
		return (span < NUM_BUCKETS) ? int'(span) : NUM_BUCKETS;
	endfunction

	function automatic int store_limit();
		return (cfg_limit < NUM_SLOTS) ? int'(cfg_limit) : NUM_SLOTS;
	endfunction

	// Updates the local histogram for one accepted request and queues the
	// result the block must return for it.
	function automatic void apply_request(input logic [CMD_W-1:0] cmd,
			input logic [LAT_W-1:0] lat, input logic [INDEX_W-1:0] idx);
		hist_result_t r;
		logic [LAT_W-1:0] bkt;
		logic [CNT_W-1:0] wide;
		r = '0;
		case (cmd)
			CMD_ADD: begin
				bkt = lat >> cfg_shift;
				wide = {{(CNT_W - LAT_W){1'b0}}, lat};
				sample_cnt += CNT_W'(1);
				lat_total  += wide;
				sq_total   += wide * wide;
				if (bkt < bucket_span()) begin
					bucket_count[BKT_W'(bkt)] += CNT_W'(1);
				end else begin
					outlier_cnt += CNT_W'(1);
					if (captured_fill >= store_limit()) begin
						r.status = ST_FULL;
					end else begin
						captured[SLOT_W'(captured_fill)] = lat;
						captured_fill++;
					end
				end
			end
			CMD_RD_BUCKET: begin
				if (idx < bucket_span())
					r.value = bucket_count[BKT_W'(idx)];
				else
					r.status = ST_IDX_ERR;
			end
			CMD_RD_OUTLIER: begin
				if (idx < captured_fill)
					r.value = {{(CNT_W - LAT_W){1'b0}}, captured[SLOT_W'(idx)]};
				else
					r.status = ST_IDX_ERR;
			end
			default: ;
		endcase
		r.samples  = sample_cnt;
		r.lat_sum  = lat_total;
		r.sq_sum   = sq_total;
		r.outliers = outlier_cnt;
		expected_results.push_back(r);
	endfunction

	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [LAT_W-1:0] lat,
			input logic [INDEX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(S_DATA_W - LAT_W - INDEX_W){1'b0}}, idx, lat};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_request(cmd, lat, idx);
	endtask

	// Stops offering requests and waits until every result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (addr)
			REG_BIN_CEILING:   cfg_bin_ceiling = data;
			REG_BUCKET_SHIFT:  cfg_shift       = data[SHIFT_W-1:0];
			REG_OUTLIER_LIMIT: cfg_limit       = data[LIMIT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic [LAT_W-1:0] bin_ceiling,
			input logic [SHIFT_W-1:0] shift, input logic [LIMIT_W-1:0] limit);
		drain_results();
		write_reg(REG_BIN_CEILING, bin_ceiling);
		write_reg(REG_BUCKET_SHIFT, CFG_DATA_W'(shift));
		write_reg(REG_OUTLIER_LIMIT, CFG_DATA_W'(limit));
	endtask

	// One random request. Adds mostly land in a live bucket or at or just
	// above the first outlier value; outlier reads only touch slots already
	// written or slots beyond the store.
	task automatic random_request();
		logic [CMD_W-1:0] cmd;
		logic [LAT_W-1:0] lat;
		logic [LAT_W-1:0] low_mask;
		logic [INDEX_W-1:0] idx;
		int pick;
		int span;
		int mode;
		span = bucket_span();
		pick = $urandom_range(99);
		lat = $urandom;
		idx = INDEX_W'($urandom);
		if (pick < 55) begin
			cmd = CMD_ADD;
			mode = $urandom_range(99);
			low_mask = ~({LAT_W{1'b1}} << cfg_shift);
			if (span > 0 && mode < 60)
				lat = (LAT_W'($urandom_range(span - 1)) << cfg_shift) | (lat & low_mask);
			else if (mode < 75)
				lat = (LAT_W'(span) << cfg_shift) | (lat & low_mask & LAT_W'($urandom_range(3)));
		end else if (pick < 75) begin
			cmd = CMD_RD_BUCKET;
			if (span > 0 && $urandom_range(99) < 80)
				idx = INDEX_W'($urandom_range(span - 1));
		end else if (pick < 95) begin
			cmd = CMD_RD_OUTLIER;
			if (captured_fill > 0 && $urandom_range(99) < 80)
				idx = INDEX_W'($urandom_range(captured_fill - 1));
			else
				idx = INDEX_W'($urandom_range(2 ** INDEX_W - 1, NUM_SLOTS));
		end else begin
			cmd = CMD_UNKNOWN;
		end
		send_request(cmd, lat, idx);
	endtask

	task automatic run_random_phase(input int count, input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) random_request();
	endtask

	// Reads right after reset: empty buckets, an empty store, unknown command.
	task automatic test_reset_state();
		send_request(CMD_RD_BUCKET, '0, '0);
		send_request(CMD_RD_BUCKET, '1, '1);
		send_request(CMD_RD_OUTLIER, '0, '1);
		send_request(CMD_UNKNOWN, '1, '1);
	endtask

	// Latency extremes, the first outlier value and a square sum that wraps.
	task automatic test_add_extremes();
		send_request(CMD_ADD, 32'd0, '1);
		send_request(CMD_ADD, 32'd1023, '0);
		send_request(CMD_ADD, 32'd1024, '0);
		send_request(CMD_ADD, 32'hFFFF_FFFF, '1);
		send_request(CMD_ADD, 32'hFFFF_FFFF, '0);
		send_request(CMD_RD_BUCKET, '0, 10'd0);
		send_request(CMD_RD_BUCKET, '0, 10'd1023);
		send_request(CMD_RD_OUTLIER, '1, 10'd0);
		send_request(CMD_RD_OUTLIER, '0, 10'd2);
	endtask

	// A full outlier store, and stored entries beyond a lowered limit.
	task automatic test_outlier_limit();
		configure(32'd1024, 5'd0, 7'd0);
		send_request(CMD_ADD, 32'd5000, '0);
		send_request(CMD_RD_OUTLIER, '0, 10'd2);
		configure(32'd1024, 5'd0, 7'd4);
		send_request(CMD_ADD, 32'd2000, '0);
		send_request(CMD_ADD, 32'd3000, '0);
	endtask

	// Empty bucket range, the widest shift, and a write to an unmapped index.
	task automatic test_register_extremes();
		configure(32'd0, 5'd0, 7'd4);
		send_request(CMD_ADD, 32'd0, '0);
		send_request(CMD_RD_BUCKET, '0, 10'd0);
		configure(32'hFFFF_FFFF, 5'd31, 7'd4);
		send_request(CMD_ADD, 32'h7FFF_FFFF, '0);
		send_request(CMD_ADD, 32'h8000_0000, '0);
		drain_results();
		write_reg(REG_UNMAPPED, '1);
		send_request(CMD_RD_BUCKET, '0, 10'd0);
		send_request(CMD_RD_BUCKET, '0, 10'd1);
	endtask

	// The receiver holds off while requests keep coming, so the block fills
	// up and has to stall its request input.
	task automatic test_backpressure();
		configure(32'd1024, 5'd0, 7'd64);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req = 1'b1;
		repeat (40) random_request();
	endtask

	task automatic test_random_traffic();
		configure(32'd1024, 5'd0, 7'd64);
		run_random_phase(335, 0, 0);
		configure(32'($urandom_range(40000, 1)), 5'd4, 7'd64);
		run_random_phase(335, 48, 0);
		configure(32'hFFFF_FFFF, 5'd22, 7'd64);
		run_random_phase(335, 0, 48);
		configure(32'($urandom), 5'($urandom_range(31, 20)), 7'($urandom_range(64)));
		run_random_phase(335, 12, 12);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_add_extremes();
		test_outlier_limit();
		test_register_extremes();
		test_backpressure();
		test_random_traffic();
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Result side: random stalls, or one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (int n = 1; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic check_field(input string name, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] seen);
		if (seen !== want) begin
			error_cnt++;
			if (error_cnt <= MAX_REPORTS)
				$display("%0t ns: %s differs, expected 0x%0h, got 0x%0h", $time, name, want, seen);
		end
	endtask

	always @(posedge clk) begin : check_results
		hist_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				error_cnt++;
				if (error_cnt <= MAX_REPORTS)
					$display("%0t ns: result with none expected, expected nothing, got 0x%0h",
						$time, m_tdata);
			end else begin
				want = expected_results.pop_front();
				check_field("status", CNT_W'(want.status), CNT_W'(m_tuser));
				check_field("value", want.value, m_tdata[63:0]);
				check_field("total_count", want.samples, m_tdata[127:64]);
				check_field("latency_sum", want.lat_sum, m_tdata[191:128]);
				check_field("square_sum", want.sq_sum, m_tdata[255:192]);
				check_field("outlier_count", want.outliers, m_tdata[319:256]);
			end
		end
	end

	// Ends a hung run; the reset clearing pass and the long hold-off both fit
	// well inside the limit.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
